FILE: rtl/jce_pkg.sv
// ----------------------------------------------------------------------------
// jce_pkg
// Shared types, constants and the keycode table of the joystick chord key
// encoder.
// ----------------------------------------------------------------------------
package jce_pkg;

  localparam int SampleBits = 12;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 12;
  localparam int HitBits = 4;
  localparam int KeyBits = 8;
  localparam int DirBits = 4;
  localparam int LayerBits = 2;

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [KeyBits-1:0] key_t;
  typedef logic [HitBits-1:0] hits_t;
  typedef logic [LayerBits-1:0] layer_t;

  typedef enum logic [DirBits-1:0] {
    DIR_UP         = 4'd0,
    DIR_UP_RIGHT   = 4'd1,
    DIR_RIGHT      = 4'd2,
    DIR_DOWN_RIGHT = 4'd3,
    DIR_DOWN       = 4'd4,
    DIR_DOWN_LEFT  = 4'd5,
    DIR_LEFT       = 4'd6,
    DIR_UP_LEFT    = 4'd7,
    DIR_CENTRE     = 4'd8
  } dir_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_CENTRE_X   = 3'd0,
    CFG_CENTRE_Y   = 3'd1,
    CFG_FULL_SCALE = 3'd2,
    CFG_WINDOW     = 3'd3,
    CFG_HITS       = 3'd4
  } cfg_idx_t;

  localparam logic [0:0] REQ_POLL = 1'b0;
  localparam logic [0:0] REQ_BUTTON = 1'b1;

  localparam key_t KEY_SPACE = 8'h2C;
  localparam key_t KEY_ENTER = 8'h28;
  localparam key_t KEY_BACKSPACE = 8'h2A;
  localparam key_t KEY_CAPS = 8'h39;

  localparam hits_t HITS_MAX = 4'd15;

  localparam sample_t CENTRE_X_RST = 12'd1995;
  localparam sample_t CENTRE_Y_RST = 12'd1882;
  localparam sample_t FULL_SCALE_RST = 12'd4095;
  localparam sample_t WINDOW_RST = 12'd300;
  localparam hits_t HITS_RST = 4'd2;

  function automatic key_t key_lookup(input layer_t layer, input logic [2:0] dir);
    key_t k;
    k = '0;
    case ({layer, dir})
      5'd0:  k = 8'h08;
      5'd1:  k = 8'h04;
      5'd2:  k = 8'h12;
      5'd3:  k = 8'h16;
      5'd4:  k = 8'h15;
      5'd5:  k = 8'h11;
      5'd6:  k = 8'h0C;
      5'd7:  k = 8'h07;
      5'd8:  k = 8'h0F;
      5'd9:  k = 8'h06;
      5'd10: k = 8'h18;
      5'd11: k = 8'h10;
      5'd12: k = 8'h13;
      5'd13: k = 8'h17;
      5'd14: k = 8'h05;
      5'd15: k = 8'h0A;
      5'd16: k = 8'h19;
      5'd17: k = 8'h1C;
      5'd18: k = 8'h14;
      5'd19: k = 8'h0B;
      5'd20: k = 8'h09;
      5'd21: k = 8'h1D;
      5'd22: k = 8'h0D;
      5'd23: k = 8'h33;
      5'd24: k = 8'h1B;
      5'd25: k = 8'h0E;
      5'd26: k = 8'h1A;
      5'd27: k = 8'h28;
      5'd28: k = 8'h2A;
      5'd29: k = 8'h39;
      5'd30: k = 8'h2C;
      5'd31: k = 8'h2C;
      default: k = '0;
    endcase
    return k;
  endfunction

  // strict window match on one axis
  function automatic logic near(input sample_t v, input sample_t t, input sample_t w);
    sample_t d;
    d = (v >= t) ? (v - t) : (t - v);
    return d < w;
  endfunction

endpackage

FILE: rtl/jce_in_if.sv
// ----------------------------------------------------------------------------
// jce_in_if
// Input channel: stick polls and button events with valid/ready handshake.
// ----------------------------------------------------------------------------
interface jce_in_if;
  logic valid;
  logic ready;
  logic req_type;
  jce_pkg::sample_t x_sample;
  jce_pkg::sample_t y_sample;
  logic sample_ok;
  logic link_up;
  logic button_a;
  logic button_b;
  logic stick_press;

  modport source (
    output valid, req_type, x_sample, y_sample, sample_ok, link_up,
           button_a, button_b, stick_press,
    input  ready
  );

  modport sink (
    input  valid, req_type, x_sample, y_sample, sample_ok, link_up,
           button_a, button_b, stick_press,
    output ready
  );
endinterface

FILE: rtl/jce_out_if.sv
// ----------------------------------------------------------------------------
// jce_out_if
// Result channel: direction, keycode, key pulse and mode flags per item.
// ----------------------------------------------------------------------------
interface jce_out_if;
  logic valid;
  logic ready;
  logic [jce_pkg::DirBits-1:0] direction;
  jce_pkg::key_t keycode;
  logic key_pulse;
  jce_pkg::layer_t layer;
  logic write_mode;
  logic caps_lock;
  logic combo_fired;

  modport source (
    output valid, direction, keycode, key_pulse, layer, write_mode,
           caps_lock, combo_fired,
    input  ready
  );

  modport sink (
    input  valid, direction, keycode, key_pulse, layer, write_mode,
           caps_lock, combo_fired,
    output ready
  );
endinterface

FILE: rtl/joystick_chord_key_encoder.sv
// ----------------------------------------------------------------------------
// joystick_chord_key_encoder
// Classifies stick polls into directions, maps them to keycodes per layer,
// debounces key pulses and tracks layer, writing mode and caps lock.
// ----------------------------------------------------------------------------
// One item is accepted every cycle unless the result register stalls:
// a beat lands in the input register, is classified and looked up in one
// pass of logic that also updates the key state, and is held in the result
// register until taken. A stalled result stops the input register only once
// it is full as well. Configuration writes take effect on the next cycle and
// are to be made by the user while no item is in flight; nothing enforces it.
module joystick_chord_key_encoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [jce_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [jce_pkg::CfgDataBits-1:0] cfg_wdata,
  jce_in_if.sink                          in_if,
  jce_out_if.source                       out_if
);

  // configuration
  jce_pkg::sample_t centre_x_r, centre_y_r, full_scale_r, window_r;
  jce_pkg::hits_t hits_needed_r;

  // key state
  jce_pkg::key_t last_key_r, last_key_nxt;
  jce_pkg::hits_t hit_count_r, hit_count_nxt;
  jce_pkg::layer_t layer_r, layer_nxt;
  logic writing_r, writing_nxt;
  logic caps_r, caps_nxt;

  // input register
  logic in_vld_r;
  logic req_type_r;
  jce_pkg::sample_t x_r, y_r;
  logic ok_r, link_r, btn_a_r, btn_b_r, press_r;

  // result register
  logic out_vld_r;
  jce_pkg::dir_t dir_r, dir_nxt;
  jce_pkg::key_t key_r, key_nxt;
  logic pulse_r, pulse_nxt;
  logic combo_r, combo_nxt;

  logic adv;
  logic take_in;
  logic nx_c, nx_f, nx_0, ny_c, ny_f, ny_0;
  jce_pkg::dir_t cls_dir;
  jce_pkg::hits_t hc_inc;
  logic qualify;

  assign adv = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || adv;
  assign take_in = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r <= jce_pkg::CENTRE_X_RST;
      centre_y_r <= jce_pkg::CENTRE_Y_RST;
      full_scale_r <= jce_pkg::FULL_SCALE_RST;
      window_r <= jce_pkg::WINDOW_RST;
      hits_needed_r <= jce_pkg::HITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jce_pkg::CFG_CENTRE_X:   centre_x_r <= cfg_wdata;
        jce_pkg::CFG_CENTRE_Y:   centre_y_r <= cfg_wdata;
        jce_pkg::CFG_FULL_SCALE: full_scale_r <= cfg_wdata;
        jce_pkg::CFG_WINDOW:     window_r <= cfg_wdata;
        jce_pkg::CFG_HITS:       hits_needed_r <= cfg_wdata[jce_pkg::HitBits-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      req_type_r <= in_if.req_type;
      x_r <= in_if.x_sample;
      y_r <= in_if.y_sample;
      ok_r <= in_if.sample_ok;
      link_r <= in_if.link_up;
      btn_a_r <= in_if.button_a;
      btn_b_r <= in_if.button_b;
      press_r <= in_if.stick_press;
    end
  end

  // window matches per axis
  always_comb begin
    nx_c = jce_pkg::near(x_r, centre_x_r, window_r);
    nx_f = jce_pkg::near(x_r, full_scale_r, window_r);
    nx_0 = jce_pkg::near(x_r, '0, window_r);
    ny_c = jce_pkg::near(y_r, centre_y_r, window_r);
    ny_f = jce_pkg::near(y_r, full_scale_r, window_r);
    ny_0 = jce_pkg::near(y_r, '0, window_r);
  end

  // first match in priority order
  always_comb begin
    if (!ok_r)              cls_dir = jce_pkg::DIR_CENTRE;
    else if (nx_c && ny_c)  cls_dir = jce_pkg::DIR_CENTRE;
    else if (nx_c && ny_0)  cls_dir = jce_pkg::DIR_UP;
    else if (nx_f && ny_0)  cls_dir = jce_pkg::DIR_UP_RIGHT;
    else if (nx_f && ny_c)  cls_dir = jce_pkg::DIR_RIGHT;
    else if (nx_f && ny_f)  cls_dir = jce_pkg::DIR_DOWN_RIGHT;
    else if (nx_c && ny_f)  cls_dir = jce_pkg::DIR_DOWN;
    else if (nx_0 && ny_f)  cls_dir = jce_pkg::DIR_DOWN_LEFT;
    else if (nx_0 && ny_c)  cls_dir = jce_pkg::DIR_LEFT;
    else if (nx_0 && ny_0)  cls_dir = jce_pkg::DIR_UP_LEFT;
    else                    cls_dir = jce_pkg::DIR_CENTRE;
  end

  always_comb begin
    last_key_nxt = last_key_r;
    hit_count_nxt = hit_count_r;
    layer_nxt = layer_r;
    writing_nxt = writing_r;
    caps_nxt = caps_r;
    dir_nxt = jce_pkg::DIR_CENTRE;
    key_nxt = '0;
    pulse_nxt = 1'b0;
    combo_nxt = 1'b0;
    hc_inc = (hit_count_r < jce_pkg::HITS_MAX) ? hit_count_r + 4'd1 : hit_count_r;
    qualify = 1'b0;
    if (req_type_r == jce_pkg::REQ_BUTTON) begin
      layer_nxt = {btn_a_r, btn_b_r};
      if (btn_a_r && btn_b_r && press_r) begin
        writing_nxt = !writing_r;
        layer_nxt = '0;
        combo_nxt = 1'b1;
      end
    end else begin
      dir_nxt = cls_dir;
      if (cls_dir == jce_pkg::DIR_CENTRE) begin
        last_key_nxt = '0;
        hit_count_nxt = '0;
      end else begin
        key_nxt = jce_pkg::key_lookup(layer_r, cls_dir[2:0]);
        qualify = (key_nxt != last_key_r) || (key_nxt == jce_pkg::KEY_SPACE) ||
                  (key_nxt == jce_pkg::KEY_ENTER) || (key_nxt == jce_pkg::KEY_BACKSPACE);
        if (qualify) begin
          hit_count_nxt = hc_inc;
          if (hc_inc >= hits_needed_r) begin
            if (writing_r) begin
              pulse_nxt = link_r;
              if (key_nxt == jce_pkg::KEY_CAPS) caps_nxt = !caps_r;
            end
            last_key_nxt = key_nxt;
            hit_count_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_key_r <= '0;
      hit_count_r <= '0;
      layer_r <= '0;
      writing_r <= 1'b1;
      caps_r <= 1'b0;
    end else if (adv) begin
      last_key_r <= last_key_nxt;
      hit_count_r <= hit_count_nxt;
      layer_r <= layer_nxt;
      writing_r <= writing_nxt;
      caps_r <= caps_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_if.ready) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_r <= dir_nxt;
      key_r <= key_nxt;
      pulse_r <= pulse_nxt;
      combo_r <= combo_nxt;
    end
  end

  assign out_if.valid = out_vld_r;
  assign out_if.direction = dir_r;
  assign out_if.keycode = key_r;
  assign out_if.key_pulse = pulse_r;
  assign out_if.layer = layer_r;
  assign out_if.write_mode = writing_r;
  assign out_if.caps_lock = caps_r;
  assign out_if.combo_fired = combo_r;

  // a pulse only leaves while writing mode is on
  a_pulse_needs_writing: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && pulse_r |-> writing_r)
    else $error("key pulse with writing mode off");

  // combo result is a centre result on layer zero
  a_combo_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && combo_r |-> (layer_r == '0) && (dir_r == jce_pkg::DIR_CENTRE) && !pulse_r)
    else $error("combo result malformed");

  // a centre poll clears the debounce state
  a_centre_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (req_type_r == jce_pkg::REQ_POLL) && (cls_dir == jce_pkg::DIR_CENTRE)
    |=> (last_key_r == '0) && (hit_count_r == '0))
    else $error("centre poll left debounce state");

  // a pulse carries a real key
  a_pulse_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && pulse_r |-> (key_r != '0) && (dir_r != jce_pkg::DIR_CENTRE))
    else $error("key pulse without key");

endmodule
